@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files of the keyed store.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define KS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a sampled edge outside reset.
`define KS_ASSERT_NEVER(lbl, expr, msg) \
  `KS_ASSERT(lbl, !(expr), msg)

`endif

@@ src/kslru_pkg.sv @@
// Shared constants and types for the keyed store with least-recently-set eviction.
// Used by the interfaces, the entry cell, the controller and the top level.
package kslru_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int STAMP_W   = 64;
  localparam int LIMIT_W   = 6;
  localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_SET    = 1'b1;

  // Running summary handed from cell to cell along the chain.
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [VAL_W-1:0]   hit_value;
    logic [CNT_W-1:0]   count;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               victim_found;
    logic [IDX_W-1:0]   victim_idx;
    logic [STAMP_W-1:0] victim_stamp;
  } scan_t;

  // Update broadcast from the controller to all cells.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
    logic               clr_en;
    logic [IDX_W-1:0]   clr_idx;
  } wr_t;

  localparam scan_t SCAN_INIT = '0;

endpackage

@@ src/kslru_ifs.sv @@
// Valid/ready channel interfaces for the keyed store: request, response, configuration.
// Depends on kslru_pkg for the field widths.
interface kslru_req_if;
  import kslru_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  modport source (output valid, mode, key, value, input ready);
  modport sink (input valid, mode, key, value, output ready);
endinterface

interface kslru_rsp_if;
  import kslru_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] found_value;
  logic             evicted;
  modport source (output valid, hit, found_value, evicted, input ready);
  modport sink (input valid, hit, found_value, evicted, output ready);
endinterface

interface kslru_cfg_if;
  import kslru_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ src/kslru_cell.sv @@
// One entry of the store: holds valid, key, value and stamp, and folds itself
// into the scan summary passed along the chain. Depends on kslru_pkg.
module kslru_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [kslru_pkg::IDX_W-1:0] cell_idx,
  input  logic [kslru_pkg::KEY_W-1:0] req_key,
  input  kslru_pkg::wr_t           wr,
  input  kslru_pkg::scan_t         scan_in,
  output kslru_pkg::scan_t         scan_out,
  output logic                     valid
);
  import kslru_pkg::*;

  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   value;
  logic [STAMP_W-1:0] stamp;
  logic               match;
  scan_t              scan_next;

  assign match = valid && (key == req_key);

  always_comb begin
    scan_next = scan_in;
    if (match && !scan_in.hit) begin
      scan_next.hit       = 1'b1;
      scan_next.hit_idx   = cell_idx;
      scan_next.hit_value = value;
    end
    scan_next.count = scan_in.count + CNT_W'(valid);
    if (!valid && !scan_in.free_found) begin
      scan_next.free_found = 1'b1;
      scan_next.free_idx   = cell_idx;
    end
    // Strict compare keeps the earlier cell on equal stamps.
    if (valid && (!scan_in.victim_found || (stamp < scan_in.victim_stamp))) begin
      scan_next.victim_found = 1'b1;
      scan_next.victim_idx   = cell_idx;
      scan_next.victim_stamp = stamp;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  // An insert into the slot just evicted must win over the clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (wr.clr_en && (wr.clr_idx == cell_idx)) begin
        valid <= 1'b0;
      end
      if (wr.en && (wr.idx == cell_idx)) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      key   <= wr.key;
      value <= wr.value;
      stamp <= wr.stamp;
    end
  end

endmodule

@@ src/kslru_ctrl.sv @@
// Controller of the keyed store: takes requests and configuration, times the
// scan through the cell chain, decides hit/evict/insert and registers the response.
// Depends on kslru_pkg and the channel interfaces.
module kslru_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  kslru_req_if.sink                req,
  kslru_rsp_if.source              rsp,
  kslru_cfg_if.sink                cfg,
  input  kslru_pkg::scan_t         scan_res,
  output logic [kslru_pkg::KEY_W-1:0] req_key,
  output kslru_pkg::wr_t           wr
);
  import kslru_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [IDX_W-1:0]     scan_cnt;
  logic                 req_mode;
  logic [VAL_W-1:0]     req_value;
  logic [STAMP_W-1:0]   set_counter;
  logic [LIMIT_W-1:0]   limit;
  logic [LIM_CMP_W-1:0] eff_limit;
  logic                 accept;
  logic                 finish_go;
  logic                 is_set;
  logic                 full;
  logic                 evict;
  logic                 ins;
  logic [IDX_W-1:0]     slot;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign finish_go = (state == S_FINISH) && (!rsp.valid || rsp.ready);
  assign is_set    = (req_mode == MODE_SET);

  always_comb begin
    eff_limit = LIM_CMP_W'(limit);
    if (eff_limit == '0) begin
      eff_limit = LIM_CMP_W'(1);
    end else if (eff_limit > LIM_CMP_W'(ENTRIES)) begin
      eff_limit = LIM_CMP_W'(ENTRIES);
    end
  end

  assign full  = LIM_CMP_W'(scan_res.count) >= eff_limit;
  assign evict = is_set && !scan_res.hit && full && scan_res.victim_found;

  // After an eviction the lowest free slot is the lower of the victim and
  // the first slot that was already empty.
  always_comb begin
    if (evict) begin
      ins  = 1'b1;
      slot = (scan_res.free_found && (scan_res.free_idx < scan_res.victim_idx)) ?
             scan_res.free_idx : scan_res.victim_idx;
    end else begin
      ins  = scan_res.free_found;
      slot = scan_res.free_idx;
    end
  end

  always_comb begin
    wr       = '0;
    wr.key   = req_key;
    wr.value = req_value;
    wr.stamp = set_counter;
    if (finish_go && is_set) begin
      if (scan_res.hit) begin
        wr.en  = 1'b1;
        wr.idx = scan_res.hit_idx;
      end else begin
        wr.en      = ins;
        wr.idx     = slot;
        wr.clr_en  = evict;
        wr.clr_idx = scan_res.victim_idx;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == IDX_W'(ENTRIES - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_cnt    <= '0;
      set_counter <= '0;
      limit       <= LIMIT_RESET;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + IDX_W'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (cfg.valid && cfg.ready) begin
        limit <= cfg.data;
      end
      if (finish_go && is_set) begin
        set_counter <= set_counter + STAMP_W'(1);
      end
      if (finish_go) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= req.mode;
      req_key   <= req.key;
      req_value <= req.value;
    end
    if (finish_go) begin
      rsp.hit         <= scan_res.hit;
      rsp.found_value <= (!is_set && scan_res.hit) ? scan_res.hit_value : '0;
      rsp.evicted     <= evict;
    end
  end

endmodule

@@ src/keyed_store_lru_eviction_top.sv @@
// Keyed store with least-recently-set eviction: a row of entry cells and its controller.
// Depends on kslru_pkg, the channel interfaces, kslru_cell, kslru_ctrl and assert_macros.svh.
//
// Usage:
//   req carries one request: mode (lookup or set), a 64-bit key and a 64-bit value.
//   rsp returns one result per request: hit, found_value (lookup hits only) and
//   evicted (a set of a new key that removed the oldest set entry).
//   cfg writes the entry limit; write it only while no request is in flight.
// Timing:
//   A request walks the summary through the chain of ENTRIES cells, one cell per
//   cycle, and the result is registered from the summary that leaves the last cell.
//   A new request is taken only after the result of the last one is registered.
// Reset:
//   All entries become empty at once, the set counter clears and the limit
//   returns to 30. No clearing pass is needed.
// Stalls:
//   A result waiting on rsp does not block the next request; a request whose scan
//   has finished holds there until the response register is free.
module keyed_store_lru_eviction_top (
  input  logic         clk,
  input  logic         rst,
  kslru_req_if.sink    req,
  kslru_rsp_if.source  rsp,
  kslru_cfg_if.sink    cfg
);
  import kslru_pkg::*;

  `include "assert_macros.svh"

  scan_t              scan_link [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;
  logic [KEY_W-1:0]   req_key;
  wr_t                wr;

  assign scan_link[0] = SCAN_INIT;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kslru_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(i)),
      .req_key  (req_key),
      .wr       (wr),
      .scan_in  (scan_link[i]),
      .scan_out (scan_link[i+1]),
      .valid    (valid_vec[i])
    );
  end

  kslru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg      (cfg),
    .scan_res (scan_link[ENTRIES]),
    .req_key  (req_key),
    .wr       (wr)
  );

  // Only one request is in the chain at a time.
  `KS_ASSERT(a_one_in_flight, (req.valid && req.ready) |=> !req.ready, "second request taken during scan")
  // An eviction happens only for a set of a key that was absent.
  `KS_ASSERT_NEVER(a_evict_on_hit, rsp.valid && rsp.evicted && rsp.hit, "eviction reported on a hit")
  // Every eviction is followed by an insert in the same update.
  `KS_ASSERT(a_evict_inserts, wr.clr_en |-> wr.en, "eviction without insert")
  // The written entry is valid afterwards, even when it is also the victim.
  `KS_ASSERT(a_write_valid, wr.en |=> valid_vec[$past(wr.idx)], "written entry not valid")

endmodule
